// ===== src/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// Shared constants, types and register codes of the stream pattern masker.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int WIN_DEPTH   = PATTERN_MAX + 1;
  localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
  localparam int IDX_W       = $clog2(WIN_DEPTH);
  localparam int GUARD_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W       = 4;
  localparam int PAT_W       = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [7:0] STAR_BYTE = 8'h2A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] eff_len;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       end_of_stream;
  } emit_t;

endpackage

// ===== src/spm_if.sv =====
// ----------------------------------------------------------------------------
// spm_if
// Valid/ready channels of the stream pattern masker: input bytes, result
// bytes and configuration writes.
// ----------------------------------------------------------------------------
interface spm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface spm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_stream;

  modport source (output valid, output out_byte, output end_of_stream, input ready);
  modport sink   (input valid, input out_byte, input end_of_stream, output ready);
endinterface

interface spm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [spm_pkg::CFG_IDX_W-1:0] index;
  logic [spm_pkg::PAT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/spm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// spm_cfg_regs
// Pattern and pattern length registers, with the length clamped to the
// supported range.
// ----------------------------------------------------------------------------
module spm_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  spm_cfg_if.sink        cfg,
  output spm_pkg::cfg_t  cfg_out
);

  logic [spm_pkg::PAT_W-1:0] pattern_bytes;
  logic [spm_pkg::LEN_W-1:0] pattern_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= spm_pkg::LEN_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        spm_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= cfg.data;
        spm_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg.data[spm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_out.pattern = pattern_bytes;
    if (pattern_length == '0) begin
      cfg_out.eff_len = spm_pkg::LEN_W'(1);
    end else if (int'(pattern_length) > spm_pkg::PATTERN_MAX) begin
      cfg_out.eff_len = spm_pkg::LEN_W'(spm_pkg::PATTERN_MAX);
    end else begin
      cfg_out.eff_len = pattern_length;
    end
  end

endmodule

// ===== src/spm_window.sv =====
// ----------------------------------------------------------------------------
// spm_window
// Byte window with parallel pattern compare; releases one decided byte per
// cycle from its front on take; takes one new byte per cycle at back if ready.
// ----------------------------------------------------------------------------
module spm_window (
  input  logic           clk,
  input  logic           rst,
  input  spm_pkg::cfg_t  cfg,
  spm_in_if.sink         stream,
  input  logic           take,
  output spm_pkg::emit_t emit
);

  logic [7:0]                   win [spm_pkg::WIN_DEPTH];
  logic [7:0]                   win_next [spm_pkg::WIN_DEPTH];
  logic [7:0]                   shifted [spm_pkg::WIN_DEPTH];
  logic [spm_pkg::FILL_W-1:0]   fill;
  logic [spm_pkg::FILL_W-1:0]   fill_next;
  logic [spm_pkg::GUARD_W-1:0]  guard;
  logic [spm_pkg::GUARD_W-1:0]  guard_next;
  spm_pkg::cfg_t                cfg_held;
  logic                         flushing;
  logic                         hit;
  logic                         enough;
  logic                         starred;
  logic                         pop;
  logic                         accept;
  logic [spm_pkg::IDX_W-1:0]    wpos;

  assign stream.ready = !flushing && (int'(fill) < spm_pkg::WIN_DEPTH);
  assign accept       = stream.valid && stream.ready;

  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < spm_pkg::PATTERN_MAX; k++) begin
      if ((k < int'(cfg_held.eff_len)) && (win[k] != cfg_held.pattern[8*k +: 8])) begin
        hit = 1'b0;
      end
    end
  end

  assign enough  = int'(fill) >= int'(cfg_held.eff_len);
  assign starred = (guard != '0) || (enough && hit);

  always_comb begin
    emit.valid         = (guard != '0) || enough || (flushing && (fill != '0));
    emit.out_byte      = starred ? spm_pkg::STAR_BYTE : win[0];
    emit.end_of_stream = flushing && (fill == spm_pkg::FILL_W'(1));
  end

  assign pop  = emit.valid && take;
  assign wpos = spm_pkg::IDX_W'(fill - spm_pkg::FILL_W'(pop));

  always_comb begin
    for (int i = 0; i < spm_pkg::WIN_DEPTH - 1; i++) begin
      shifted[i] = pop ? win[i+1] : win[i];
    end
    shifted[spm_pkg::WIN_DEPTH-1] = win[spm_pkg::WIN_DEPTH-1];
    for (int i = 0; i < spm_pkg::WIN_DEPTH; i++) begin
      win_next[i] = (accept && (wpos == spm_pkg::IDX_W'(i))) ? stream.data_byte : shifted[i];
    end
  end

  assign fill_next = fill + spm_pkg::FILL_W'(accept) - spm_pkg::FILL_W'(pop);

  always_comb begin
    guard_next = guard;
    if (pop) begin
      if (guard != '0) begin
        guard_next = guard - spm_pkg::GUARD_W'(1);
      end else if (enough && hit) begin
        guard_next = spm_pkg::GUARD_W'(cfg_held.eff_len - spm_pkg::LEN_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill             <= '0;
      guard            <= '0;
      flushing         <= 1'b0;
      cfg_held.pattern <= '0;
      cfg_held.eff_len <= spm_pkg::LEN_W'(1);
    end else begin
      fill  <= fill_next;
      guard <= guard_next;
      if (accept) begin
        cfg_held <= cfg;
      end
      if (accept && stream.last_byte) begin
        flushing <= 1'b1;
      end else if (pop && emit.end_of_stream) begin
        flushing <= 1'b0;
      end
    end
  end

endmodule

// ===== src/spm_out_reg.sv =====
// ----------------------------------------------------------------------------
// spm_out_reg
// Result register between the window and the downstream channel.
// ----------------------------------------------------------------------------
module spm_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  spm_pkg::emit_t emit,
  output logic           take,
  spm_out_if.source      result
);

  logic       valid;
  logic [7:0] out_byte;
  logic       end_of_stream;

  assign take = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit.valid) begin
      out_byte      <= emit.out_byte;
      end_of_stream <= emit.end_of_stream;
    end
  end

  assign result.valid         = valid;
  assign result.out_byte      = out_byte;
  assign result.end_of_stream = end_of_stream;

endmodule

// ===== src/stream_pattern_masker_core.sv =====
// ----------------------------------------------------------------------------
// stream_pattern_masker_core
// Byte stream filter that replaces each occurrence of a pattern by asterisks.
// ----------------------------------------------------------------------------
// Takes and gives one byte per cycle when not stalled. A byte leaves once it
// can no longer start a match, so results trail the input by up to
// pattern_length - 1 bytes plus the result register; the one-byte-a-cycle
// front of the window sets the rate. After a byte marked last the input is
// held until the window has drained, up to PATTERN_MAX + 1 results, and the
// final result carries end_of_stream. Write the registers only while idle.
module stream_pattern_masker_core (
  input  logic      clk,
  input  logic      rst,
  spm_cfg_if.sink   cfg,
  spm_in_if.sink    stream,
  spm_out_if.source result
);

  spm_pkg::cfg_t  cfg_val;
  spm_pkg::emit_t emit;
  logic           take;

  spm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_out (cfg_val)
  );

  spm_window u_window (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_val),
    .stream (stream),
    .take   (take),
    .emit   (emit)
  );

  spm_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .emit   (emit),
    .take   (take),
    .result (result)
  );

endmodule

// ===== src/spm_checker.sv =====
// ----------------------------------------------------------------------------
// spm_checker
// Port-level checks of the stream pattern masker, bound to the top level.
// ----------------------------------------------------------------------------
module spm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_eos
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_eos))
    else $error("stalled result changed");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken while flushing");

  a_blocked_drains: assert property (@(posedge clk) disable iff (rst)
    !in_ready && !out_valid |=> out_valid)
    else $error("input held with no result on the way");

endmodule

bind stream_pattern_masker_core spm_checker u_spm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (stream.valid),
  .in_ready  (stream.ready),
  .in_last   (stream.last_byte),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_byte  (result.out_byte),
  .out_eos   (result.end_of_stream)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stream_pattern_masker_core.
// ----------------------------------------------------------------------------
// Streams bytes through the masker while a shadow window, kept in step with
// every accepted input item and register write, works out which bytes should
// leave as asterisks. Each result item is checked against the oldest pending
// byte. A directed opener covers the default settings, the length clamps and
// settings changed with bytes still held; random streams with planted pattern
// copies follow, over varied patterns and lengths, with bursty back-pressure.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [7:0] value;
  logic       eos;
} masked_byte_t;

class mask_tracker;
  logic [spm_pkg::PAT_W-1:0] pattern;
  logic [spm_pkg::LEN_W-1:0] length_reg;
  logic [7:0]                window [spm_pkg::PATTERN_MAX];
  int                        fill;
  masked_byte_t              masked_q [$];
  int                        errors;

  function new();
    pattern    = '0;
    length_reg = 4'd1;
    fill       = 0;
    errors     = 0;
    foreach (window[k]) window[k] = 8'h00;
  endfunction

  function void write_reg(spm_pkg::reg_idx_t idx, logic [spm_pkg::PAT_W-1:0] value);
    case (idx)
      spm_pkg::REG_PATTERN_BYTES:  pattern = value;
      spm_pkg::REG_PATTERN_LENGTH: length_reg = value[spm_pkg::LEN_W-1:0];
      default: ;
    endcase
  endfunction

  function void emit(logic [7:0] value);
    masked_byte_t b;
    b.value = value;
    b.eos   = 1'b0;
    masked_q.push_back(b);
  endfunction

  function void drop(int n);
    for (int k = 0; k < spm_pkg::PATTERN_MAX; k++)
      window[k] = (k + n < fill) ? window[k + n] : 8'h00;
    fill -= n;
  endfunction

  function void take_byte(logic [7:0] data, logic last);
    int           len;
    int           count;
    bit           hit;
    masked_byte_t tail;
    len   = (length_reg == 0) ? 1 :
            (length_reg > spm_pkg::PATTERN_MAX) ? spm_pkg::PATTERN_MAX : length_reg;
    count = 0;
    if (fill >= spm_pkg::PATTERN_MAX) fill = spm_pkg::PATTERN_MAX - 1;
    window[fill] = data;
    fill++;
    while (fill >= len) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++)
        if (window[k] !== pattern[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        repeat (len) emit(spm_pkg::STAR_BYTE);
        count += len;
        drop(len);
      end else begin
        emit(window[0]);
        count++;
        drop(1);
      end
    end
    if (last) begin
      for (int k = 0; k < fill; k++) emit(window[k]);
      count += fill;
      drop(fill);
      if (count > 0) begin
        tail     = masked_q.pop_back();
        tail.eos = 1'b1;
        masked_q.push_back(tail);
      end
    end
  endfunction

  function void check_byte(logic [7:0] value, logic eos);
    masked_byte_t want;
    if (masked_q.size() == 0) begin
      $error("out_byte: expected none, got %h", value);
      errors++;
    end else begin
      want = masked_q.pop_front();
      if (value !== want.value) begin
        $error("out_byte: expected %h, got %h", want.value, value);
        errors++;
      end
      if (eos !== want.eos) begin
        $error("end_of_stream: expected %b, got %b", want.eos, eos);
        errors++;
      end
    end
  endfunction

  function int pending();
    return masked_q.size();
  endfunction
endclass

module tb_top;
  localparam int ITEM_COUNT = 410;
  localparam int CALM_AFTER = 350;

  logic clk;
  logic rst;

  spm_cfg_if cfg_if ();
  spm_in_if  stream_if ();
  spm_out_if result_if ();

  stream_pattern_masker_core dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .stream (stream_if),
    .result (result_if)
  );

  mask_tracker               tracker;
  bit                        idle_on;
  int                        sent;
  int                        stall_left;
  logic [spm_pkg::PAT_W-1:0] cur_pattern;
  int                        cur_len;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb_top: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready)
        tracker.write_reg(spm_pkg::reg_idx_t'(cfg_if.index), cfg_if.data);
      if (stream_if.valid && stream_if.ready)
        tracker.take_byte(stream_if.data_byte, stream_if.last_byte);
      if (result_if.valid && result_if.ready)
        tracker.check_byte(result_if.out_byte, result_if.end_of_stream);
    end
  end

  initial begin
    result_if.ready = 1'b0;
    stall_left      = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_if.ready = 1'b0;
        stall_left--;
      end else if (idle_on && result_if.ready && $urandom_range(0, 4) == 0) begin
        result_if.ready = 1'b0;
        stall_left      = $urandom_range(0, 6);
      end else begin
        result_if.ready = 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      stream_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    stream_if.valid     = 1'b1;
    stream_if.data_byte = b;
    stream_if.last_byte = last;
    do @(posedge clk); while (!stream_if.ready);
    sent++;
    if (sent >= CALM_AFTER) idle_on = 1'b0;
  endtask

  task automatic send_packed(logic [63:0] bytes, int n, logic last);
    for (int i = 0; i < n; i++)
      send_byte(bytes[8*i +: 8], last && (i == n - 1));
  endtask

  task automatic set_reg(spm_pkg::reg_idx_t idx, logic [spm_pkg::PAT_W-1:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    if (idx == spm_pkg::REG_PATTERN_BYTES) begin
      cur_pattern = value;
    end else begin
      cur_len = (value[spm_pkg::LEN_W-1:0] == 0) ? 1 :
                (value[spm_pkg::LEN_W-1:0] > spm_pkg::PATTERN_MAX) ? spm_pkg::PATTERN_MAX :
                value[spm_pkg::LEN_W-1:0];
    end
  endtask

  task automatic set_both(logic [spm_pkg::PAT_W-1:0] pattern,
                          logic [spm_pkg::LEN_W-1:0] len);
    set_reg(spm_pkg::REG_PATTERN_BYTES, pattern);
    set_reg(spm_pkg::REG_PATTERN_LENGTH, {{(spm_pkg::PAT_W-spm_pkg::LEN_W){1'b0}}, len});
  endtask

  // hold input until every pending byte is out, then let the window settle
  task automatic settle();
    @(negedge clk);
    stream_if.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [spm_pkg::PAT_W-1:0] rand_pattern();
    logic [spm_pkg::PAT_W-1:0] p;
    for (int k = 0; k < spm_pkg::PATTERN_MAX; k++)
      p[8*k +: 8] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) :
                                                  8'(8'h61 + $urandom_range(0, 1));
    return p;
  endfunction

  function automatic logic [spm_pkg::LEN_W-1:0] rand_length();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(9, 15));
    if ($urandom_range(0, 19) == 0) return 4'd0;
    return 4'($urandom_range(1, spm_pkg::PATTERN_MAX));
  endfunction

  task automatic send_stream(int n);
    logic [7:0] bytes_q [$];
    int         cut;
    int         run;
    while (bytes_q.size() < n) begin
      if ($urandom_range(0, 2) == 0) begin
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cur_len) : cur_len;
        for (int j = 0; j < run; j++) bytes_q.push_back(cur_pattern[8*j +: 8]);
      end else if ($urandom_range(0, 1) == 0) begin
        bytes_q.push_back(cur_pattern[8*$urandom_range(0, cur_len - 1) +: 8]);
      end else begin
        bytes_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, bytes_q.size() - 1) : 0;
    for (int i = 0; i < bytes_q.size(); i++) begin
      if (cut > 0 && i == cut) begin
        settle();
        if ($urandom_range(0, 1) == 0)
          set_reg(spm_pkg::REG_PATTERN_BYTES, rand_pattern());
        else
          set_reg(spm_pkg::REG_PATTERN_LENGTH,
                  {{(spm_pkg::PAT_W-spm_pkg::LEN_W){1'b0}}, rand_length()});
      end
      send_byte(bytes_q[i], i == bytes_q.size() - 1);
    end
  endtask

  initial begin
    tracker             = new();
    rst                 = 1'b1;
    idle_on             = 1'b1;
    sent                = 0;
    cur_pattern         = '0;
    cur_len             = 1;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = spm_pkg::REG_PATTERN_BYTES;
    cfg_if.data         = '0;
    stream_if.valid     = 1'b0;
    stream_if.data_byte = 8'h00;
    stream_if.last_byte = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    settle();
    set_both(64'h636261, 4'd3);
    send_packed(64'h0063_6261_6362_6161, 7, 1'b1);

    // zero length behaves as one
    settle();
    set_both(64'hFF, 4'd0);
    send_packed(64'h01FF, 2, 1'b1);

    // oversize length clamps to PATTERN_MAX
    settle();
    set_both({spm_pkg::PAT_W{1'b1}}, 4'd15);
    send_packed({spm_pkg::PAT_W{1'b1}}, 8, 1'b1);

    // change both registers with bytes still held
    settle();
    set_both(64'h636261, 4'd3);
    send_packed(64'h6261, 2, 1'b0);
    settle();
    set_both(64'h62, 4'd1);
    send_byte(8'h63, 1'b1);

    while (sent < ITEM_COUNT) begin
      settle();
      set_both(rand_pattern(), rand_length());
      repeat ($urandom_range(1, 3))
        if (sent < ITEM_COUNT) send_stream($urandom_range(1, 24));
    end
    settle();

    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end
endmodule
